// File: src/bsit_pkg.sv
// Shared types, codes and defaults for the bit set interning table.
// Used by the controller, the datapath and the top level; no dependencies.
package bsit_pkg;

    localparam int DEF_MAX_SETS  = 256;
    localparam int DEF_SET_BYTES = 32;

    localparam int CFG_W    = 6;
    localparam int NUM_W    = 8;
    localparam int STAT_W   = 3;
    localparam int SCOUNT_W = 9;
    localparam int OUT_W    = 24;

    localparam logic [CFG_W-1:0] SET_BYTES_RESET = 6'd32;

    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_LENGTH    = 3'd4;

    typedef struct packed {
        logic                byte_in;
        logic                k_inc;
        logic                e_inc;
        logic                k_clr;
        logic                wr_en;
        logic                res_set;
        logic [STAT_W-1:0]   res_code;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic closing;
        logic len_err;
        logic e_end;
        logic mismatch;
        logic k_last;
        logic wr_last;
        logic search;
        logic full;
        logic out_free;
    } stat_t;

endpackage

// File: src/bsit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/bsit_dp.sv
// Datapath: byte assembly, set store, counters, compare and result register.
// Depends on bsit_pkg and bsit_ram.
module bsit_dp
    import bsit_pkg::*;
#(
    parameter int MAX_SETS  = DEF_MAX_SETS,
    parameter int SET_BYTES = DEF_SET_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tlast,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_valid,
    input  logic [CFG_W-1:0]  cfg_data,
    input  cmd_t              cmd,
    output stat_t             stat
);

    localparam int DEPTH = MAX_SETS * SET_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BAW   = (SET_BYTES > 1) ? $clog2(SET_BYTES) : 1;
    localparam int EW    = $clog2(MAX_SETS + 1);
    localparam int KW    = $clog2(SET_BYTES + 1);
    localparam int PW    = $clog2(SET_BYTES + 2);
    localparam int POS_LIMIT = SET_BYTES + 1;

    logic [PW-1:0]       pos_reg, pos_next, count_reg, count_next;
    logic                mode_reg, mode_next;
    logic [CFG_W-1:0]    set_bytes_reg, set_bytes_next;
    logic [EW-1:0]       entry_count_reg, entry_count_next;
    logic [EW-1:0]       e_reg, e_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [NUM_W-1:0]    res_num_reg, res_num_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    m_data_reg, m_data_next;
    logic [PW-1:0]       pos_inc;
    logic                closing;
    logic [7:0]          buf_rdata, store_rdata, store_wdata;
    logic [AW-1:0]       store_raddr, store_waddr;
    logic [BAW-1:0]      buf_raddr, buf_waddr;
    logic                buf_we;

    assign closing = cmd.byte_in && s_tlast;
    assign pos_inc = (32'(pos_reg) < POS_LIMIT) ? pos_reg + PW'(1) : pos_reg;

    assign buf_we      = cmd.byte_in && (32'(pos_reg) < SET_BYTES);
    assign buf_waddr   = pos_reg[BAW-1:0];
    assign buf_raddr   = k_reg[BAW-1:0];
    assign store_raddr = AW'(e_reg) * AW'(SET_BYTES) + AW'(k_reg);
    assign store_waddr = AW'(entry_count_reg) * AW'(SET_BYTES) + AW'(k_reg);
    assign store_wdata = (32'(k_reg) < 32'(set_bytes_reg)) ? buf_rdata : 8'd0;

    bsit_ram #(.WIDTH(8), .DEPTH(SET_BYTES)) u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (s_tdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    bsit_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    always_comb begin
        pos_next         = pos_reg;
        count_next       = count_reg;
        mode_next        = mode_reg;
        set_bytes_next   = cfg_valid ? cfg_data : set_bytes_reg;
        entry_count_next = entry_count_reg;
        e_next           = e_reg;
        k_next           = k_reg;
        res_num_next     = res_num_reg;
        res_status_next  = res_status_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_tready;

        if (cmd.byte_in) begin
            pos_next = closing ? '0 : pos_inc;
        end
        if (closing) begin
            count_next = pos_inc;
            mode_next  = s_tuser;
            e_next     = '0;
            k_next     = '0;
        end
        if (cmd.k_inc) begin
            k_next = k_reg + KW'(1);
        end
        if (cmd.k_clr) begin
            k_next = '0;
        end
        if (cmd.e_inc) begin
            e_next = e_reg + EW'(1);
            k_next = '0;
        end
        if (cmd.res_set) begin
            res_status_next = cmd.res_code;
            unique case (cmd.res_code)
                ST_FOUND:    res_num_next = NUM_W'(32'(e_reg));
                ST_INSERTED: res_num_next = NUM_W'(32'(entry_count_reg));
                default:     res_num_next = '0;
            endcase
            if (cmd.res_code == ST_INSERTED) begin
                entry_count_next = entry_count_reg + EW'(1);
            end
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({SCOUNT_W'(32'(entry_count_reg)), res_status_reg,
                                   res_num_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            set_bytes_reg   <= SET_BYTES_RESET;
            entry_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            set_bytes_reg   <= set_bytes_next;
            entry_count_reg <= entry_count_next;
            m_valid_reg     <= m_valid_next;
        end
        count_reg      <= count_next;
        mode_reg       <= mode_next;
        e_reg          <= e_next;
        k_reg          <= k_next;
        res_num_reg    <= res_num_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    assign stat.closing  = s_tlast;
    assign stat.len_err  = (set_bytes_reg == '0) || (32'(set_bytes_reg) > SET_BYTES) ||
                           (32'(count_reg) != 32'(set_bytes_reg));
    assign stat.e_end    = (e_reg == entry_count_reg);
    assign stat.mismatch = (store_rdata != buf_rdata);
    assign stat.k_last   = (32'(k_reg) + 1 == 32'(set_bytes_reg));
    assign stat.wr_last  = (32'(k_reg) == SET_BYTES - 1);
    assign stat.search   = mode_reg;
    assign stat.full     = (32'(entry_count_reg) >= MAX_SETS);
    assign stat.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: src/bsit_ctrl.sv
// Controller state machine: sequences byte loading, the store walk and the insert.
// Depends on bsit_pkg.
module bsit_ctrl
    import bsit_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_MISS  = 3'd4;
    localparam logic [2:0] S_WRD   = 3'd5;
    localparam logic [2:0] S_WWR   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.byte_in = 1'b1;
                    if (stat.closing) begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (stat.len_err) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_LENGTH;
                    state_next   = S_OUT;
                end else if (stat.e_end) begin
                    state_next = S_MISS;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: state_next = S_CMP;
            S_CMP: begin
                if (stat.mismatch) begin
                    cmd.e_inc  = 1'b1;
                    state_next = S_CHECK;
                end else if (stat.k_last) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_FOUND;
                    state_next   = S_OUT;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_RD;
                end
            end
            S_MISS: begin
                if (stat.search) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                    state_next   = S_OUT;
                end else if (stat.full) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_FULL;
                    state_next   = S_OUT;
                end else begin
                    cmd.k_clr  = 1'b1;
                    state_next = S_WRD;
                end
            end
            S_WRD: state_next = S_WWR;
            S_WWR: begin
                cmd.wr_en = 1'b1;
                if (stat.wr_last) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_INSERTED;
                    state_next   = S_OUT;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_WRD;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// File: src/bitset_interning_table_top.sv
// Top level of the bit set interning table: controller plus datapath.
// Depends on bsit_pkg, bsit_ctrl, bsit_dp and bsit_ram.
//
// Usage. A set enters on the s_ channel as a run of byte transfers, one per
// cycle, with s_tlast on the final byte; s_tuser on that final byte picks
// the operation (0 insert if absent, 1 search only). Each closing byte gives
// one result transfer on the m_ channel: set number, status code and stored
// count. The cfg_ channel, always ready, writes the bytes-per-set register;
// the user must write it only while the block is idle; nothing enforces it.
//
// Lookup sequence. After the closing byte the walk passes a check state for
// each entry and, per compared byte, an address state and then a compare of
// the registered data, leaving an entry at its first mismatching byte; a hit
// ends on its last compared byte. A miss then passes a state that chooses
// not found, full or insert, and an insert writes all SET_BYTES bytes of the
// entry, each in a read and a write state. A length error is decided in the
// first check state. The output state loads the result once the output
// register is free and then returns to idle, where the input is ready again.
//
// Reset clears the state machine, the entry count, the byte position and the
// output valid; the register returns to 32. When the receiver stalls, the
// result holds in the output register and the next set may still load; its
// result waits until the output register is free.
module bitset_interning_table_top
    import bsit_pkg::*;
#(
    parameter int MAX_SETS  = DEF_MAX_SETS,
    parameter int SET_BYTES = DEF_SET_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] set_byte
    input  logic              s_tuser,   // [0] mode
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [7:0] set_number, [10:8] status,
                                         // [19:11] stored_count, [23:20] zero
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    bsit_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsit_dp #(.MAX_SETS(MAX_SETS), .SET_BYTES(SET_BYTES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tlast   (s_tlast),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Status codes above length error never appear.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:8] <= ST_LENGTH))
        else $error("bad status code");

    // Only found and inserted results carry a nonzero set number.
    a_num_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[10:8] == ST_NOT_FOUND || m_tdata[10:8] == ST_FULL ||
                      m_tdata[10:8] == ST_LENGTH)) |-> (m_tdata[7:0] == 8'd0))
        else $error("nonzero number on a miss");

    // The stored count never exceeds the table size.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[19:11]) <= MAX_SETS))
        else $error("stored count out of range");

    // Input ready drops once a closing byte is accepted.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input ready during lookup");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the bit set interning table.
// Drives byte runs and bytes-per-set settings, predicts every result in a
// scoreboard class; depends on bsit_pkg and bitset_interning_table_top.
module tb;
    import bsit_pkg::*;

    localparam int  HELD_LIMIT  = DEF_MAX_SETS;
    localparam int  WIDTH_BYTES = DEF_SET_BYTES;
    localparam int  ITEM_TARGET = 1650;
    localparam longint CYCLE_LIMIT = 200_000_000;

    typedef struct {
        logic [NUM_W-1:0]    number;
        logic [STAT_W-1:0]   status;
        logic [SCOUNT_W-1:0] held;
    } lookup_t;

    // Scoreboard: keeps its own copy of the table and the expected lookups.
    class intern_scoreboard;
        bit [7:0]    store [HELD_LIMIT][WIDTH_BYTES];
        bit [7:0]    asm_buf [WIDTH_BYTES];
        int unsigned pos;
        int unsigned held;
        int unsigned set_bytes;
        lookup_t     lookup_q[$];
        int          errors;

        function new();
            pos       = 0;
            held      = 0;
            set_bytes = 32'(SET_BYTES_RESET);
            errors    = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch @%0t: %s", $realtime, msg);
        endtask

        function void push(int unsigned number, logic [STAT_W-1:0] status);
            lookup_t r;
            r.number = number[NUM_W-1:0];
            r.status = status;
            r.held   = held[SCOUNT_W-1:0];
            lookup_q.push_back(r);
        endfunction

        // Note one accepted input transfer and predict its result, if any.
        function void take_byte(bit search_only, bit [7:0] b, bit closing);
            int unsigned count;
            int unsigned len;
            int          hit;
            bit          same;
            if (pos < WIDTH_BYTES) asm_buf[pos] = b;
            if (pos < WIDTH_BYTES + 1) pos++;
            if (!closing) return;
            count = pos;
            pos   = 0;
            len   = set_bytes;
            if (len == 0 || len > WIDTH_BYTES || count != len) begin
                push(0, ST_LENGTH);
                return;
            end
            hit = -1;
            for (int e = 0; e < held && hit < 0; e++) begin
                same = 1'b1;
                for (int k = 0; k < len; k++)
                    if (store[e][k] != asm_buf[k]) same = 1'b0;
                if (same) hit = e;
            end
            if (hit >= 0) begin
                push(hit, ST_FOUND);
            end else if (search_only) begin
                push(0, ST_NOT_FOUND);
            end else if (held >= HELD_LIMIT) begin
                push(0, ST_FULL);
            end else begin
                // New entries are zero padded up to the full entry width.
                for (int k = 0; k < WIDTH_BYTES; k++)
                    store[held][k] = (k < len) ? asm_buf[k] : 8'h00;
                held++;
                push(held - 1, ST_INSERTED);
            end
        endfunction

        task check_result(logic [OUT_W-1:0] data);
            lookup_t r;
            if (lookup_q.size() == 0) begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            r = lookup_q.pop_front();
            if (data[7:0] !== r.number)
                report($sformatf("set_number %0d, expected %0d", data[7:0], r.number));
            if (data[10:8] !== r.status)
                report($sformatf("status %0d, expected %0d", data[10:8], r.status));
            if (data[19:11] !== r.held)
                report($sformatf("stored_count %0d, expected %0d", data[19:11], r.held));
            if (data[23:20] !== 4'h0)
                report($sformatf("pad bits %h not zero", data[23:20]));
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              s_tuser;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;

    intern_scoreboard sb;
    bit               steady;       // when set, neither side idles
    int               items_sent;
    longint           cycles;
    bit [7:0]         prev_set [$];

    bitset_interning_table_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Mostly short gaps, a few long ones, none at all during steady phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Result checking and the run limit.
    always @(posedge aclk) begin
        cycles++;
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls on the result channel.
    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0) stall = pick_gap();
            end
        end
    end

    // One byte transfer, followed by an optional idle gap.
    task automatic send_byte(bit mode, bit [7:0] b, bit closing);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= mode;
        s_tlast  <= closing;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(mode, b, closing);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_set(bit mode, bit [7:0] bytes [$]);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(i == bytes.size() - 1 ? mode : bit'($urandom_range(0, 1)),
                      bytes[i], i == bytes.size() - 1);
        prev_set = bytes;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.lookup_q.size() != 0) @(posedge aclk);
        // A length error or insert may still be finishing in the datapath.
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_set_bytes(bit [CFG_W-1:0] v);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_bytes = 32'(v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_set(bit mode, int len, bit [7:0] fill);
        bit [7:0] bytes [$];
        for (int i = 0; i < len; i++) bytes.push_back(fill);
        send_set(mode, bytes);
    endtask

    // One randomized set; short alphabets and replays make hits likely.
    task automatic random_set();
        bit [7:0] bytes [$];
        int       cfg_len;
        int       len;
        bit       narrow;
        cfg_len = sb.set_bytes;
        if (prev_set.size() > 0 && $urandom_range(0, 3) == 0) begin
            bytes = prev_set;
        end else begin
            if ($urandom_range(0, 4) != 0)
                len = (cfg_len >= 1 && cfg_len <= WIDTH_BYTES) ? cfg_len
                                                               : $urandom_range(1, 34);
            else
                len = $urandom_range(1, 40);
            narrow = $urandom_range(0, 1);
            for (int i = 0; i < len; i++)
                bytes.push_back(narrow ? 8'($urandom_range(0, 2)) : 8'($urandom));
        end
        send_set($urandom_range(0, 9) < 7 ? 1'b0 : 1'b1, bytes);
    endtask

    initial begin
        int         phase_items;
        bit [CFG_W-1:0] plan [$];
        sb         = new();
        steady     = 1'b0;
        items_sent = 0;
        cycles     = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at the reset width of 32 bytes.
        directed_set(1'b1, 32, 8'hFF);   // empty table: not found
        directed_set(1'b0, 32, 8'hFF);   // inserted as number 0
        directed_set(1'b0, 32, 8'hFF);   // found again
        directed_set(1'b1, 32, 8'h00);   // not found
        directed_set(1'b0, 32, 8'h00);   // inserted
        directed_set(1'b0, 31, 8'hA5);   // one byte short
        directed_set(1'b0, 40, 8'h5A);   // overlong, counter saturates
        write_set_bytes(6'd1);
        directed_set(1'b1, 1, 8'hFF);    // truncated compare hits entry 0
        directed_set(1'b0, 1, 8'h81);
        directed_set(1'b0, 2, 8'h81);    // length error
        write_set_bytes(6'd0);           // invalid width: all length errors
        directed_set(1'b0, 1, 8'h12);
        write_set_bytes(6'd63);
        directed_set(1'b0, 33, 8'h34);

        // Random phases; the fill phase drives the table to full. The
        // directed part and the fill phase take 525 of the items.
        plan = '{6'd2, 6'd3, 6'd1, 6'd0, 6'd4, 6'd63, 6'd8, 6'd32,
                 6'd1, 6'd2, 6'd5, 6'd16, 6'd33, 6'd3, 6'd1, 6'd2};
        foreach (plan[p]) begin
            write_set_bytes(plan[p]);
            steady = (p % 3 == 2);
            if (p == 8) begin
                for (int v = 0; v < 256; v++) begin
                    bit [7:0] one [$];
                    one = '{8'(v)};
                    send_set(1'b0, one);
                end
            end else begin
                phase_items = items_sent;
                while (items_sent - phase_items < (ITEM_TARGET - 600) / 15)
                    random_set();
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.lookup_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: sim.f
src/bsit_pkg.sv
src/bsit_ram.sv
src/bsit_dp.sv
src/bsit_ctrl.sv
src/bitset_interning_table_top.sv
dv/tb.sv
